// ----- rtl/tsa_pkg.sv -----
// Shared types and constants of the slot allocator.
package tsa_pkg;

	localparam int SLOTS_DEF    = 16;
	localparam int EXP_W        = 32;
	localparam int LIFE_W       = 16;
	localparam int LIFE_RESET   = 100;
	localparam int SLOT_W       = 4;
	localparam int LIVE_W       = 5;
	localparam int OUT_TDATA_W  = 16;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [LIVE_W-1:0] live_count;
	} res_t;

endpackage

// ----- rtl/tsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/tsa_ctrl.sv -----
// Scan sequencer: busy bits, live count, oldest-expiry search and expiry sweep.
module tsa_ctrl #(
	parameter int SLOTS = tsa_pkg::SLOTS_DEF,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	parameter int CW    = $clog2(SLOTS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       mode,
	input  logic [tsa_pkg::EXP_W-1:0]  now_time,
	input  logic [tsa_pkg::LIFE_W-1:0] lifetime,
	output logic                       idle,
	output logic                       ram_we,
	output logic [IW-1:0]              ram_waddr,
	output logic [tsa_pkg::EXP_W-1:0]  ram_wdata,
	output logic                       ram_re,
	output logic [IW-1:0]              ram_raddr,
	input  logic [tsa_pkg::EXP_W-1:0]  ram_rdata,
	input  logic                       res_ready,
	output tsa_pkg::res_t              res
);

	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	tsa_pkg::state_t            state_q;
	logic                       mode_q;
	logic [tsa_pkg::EXP_W-1:0]  now_q;
	logic [tsa_pkg::EXP_W-1:0]  exp_new_q;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              idx_s1;
	logic                       rd_v_s1;
	logic [IW-1:0]              oldest_idx_q;
	logic [tsa_pkg::EXP_W-1:0]  oldest_exp_q;
	logic [IW-1:0]              grant_q;
	logic                       evict_q;
	logic [SLOTS-1:0]           busy_q;
	logic [CW-1:0]              cnt_q;

	logic                       is_alloc;
	logic                       free_hit;
	logic                       commit;
	logic [IW-1:0]              sel_idx;
	logic [CW-1:0]              cnt_fin;
	logic [tsa_pkg::EXP_W:0]    exp_sum;
	logic                       expire_s1;

	assign is_alloc  = (mode_q == tsa_pkg::MODE_ALLOC);
	assign free_hit  = (state_q == tsa_pkg::ST_SCAN) && is_alloc && !busy_q[idx_q];
	assign commit    = (state_q == tsa_pkg::ST_FIN) && res_ready;
	assign sel_idx   = evict_q ? oldest_idx_q : grant_q;
	assign cnt_fin   = (is_alloc && !evict_q) ? cnt_q + CW'(1) : cnt_q;
	assign exp_sum   = {1'b0, now_time} + (tsa_pkg::EXP_W + 1)'(lifetime);
	assign expire_s1 = rd_v_s1 && !is_alloc && busy_q[idx_s1] && (ram_rdata <= now_q);

	assign idle      = (state_q == tsa_pkg::ST_IDLE);
	assign ram_re    = (state_q == tsa_pkg::ST_SCAN) && !free_hit;
	assign ram_raddr = idx_q;
	assign ram_we    = commit && is_alloc;
	assign ram_waddr = sel_idx;
	assign ram_wdata = exp_new_q;

	always_comb begin
		res.valid      = (state_q == tsa_pkg::ST_FIN);
		res.slot       = is_alloc ? tsa_pkg::SLOT_W'(sel_idx) : '0;
		res.evicted    = is_alloc && evict_q;
		res.live_count = tsa_pkg::LIVE_W'(cnt_fin);
	end

	// Payload of the item under work.
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q    <= mode;
			now_q     <= now_time;
			exp_new_q <= exp_sum[tsa_pkg::EXP_W] ? '1 : exp_sum[tsa_pkg::EXP_W-1:0];
		end
		if (free_hit) begin
			grant_q <= idx_q;
		end
		idx_s1 <= idx_q;
		// Strict compare keeps the lowest index on equal expiry.
		if (rd_v_s1 && is_alloc && (idx_s1 == '0 || ram_rdata < oldest_exp_q)) begin
			oldest_idx_q <= idx_s1;
			oldest_exp_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsa_pkg::ST_IDLE;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			evict_q <= 1'b0;
			busy_q  <= '0;
			cnt_q   <= '0;
		end else begin
			rd_v_s1 <= ram_re;
			if (expire_s1) begin
				busy_q[idx_s1] <= 1'b0;
				cnt_q          <= cnt_q - CW'(1);
			end
			case (state_q)
				tsa_pkg::ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						evict_q <= 1'b0;
						state_q <= tsa_pkg::ST_SCAN;
					end
				end
				tsa_pkg::ST_SCAN: begin
					if (free_hit) begin
						state_q <= tsa_pkg::ST_FIN;
					end else if (idx_q == LAST_IDX) begin
						state_q <= tsa_pkg::ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				tsa_pkg::ST_DRAIN: begin
					evict_q <= is_alloc;
					state_q <= tsa_pkg::ST_FIN;
				end
				tsa_pkg::ST_FIN: begin
					if (commit) begin
						if (is_alloc) begin
							busy_q[sel_idx] <= 1'b1;
							cnt_q           <= cnt_fin;
						end
						state_q <= tsa_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tsa_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/ttl_slot_allocator.sv -----
// Top level of the expiring slot allocator: config register, sequencer, RAM, output word.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: now_time[31:0]; tuser: mode
//  m_*     | out | m_tvalid/m_tready  | tdata: slot[3:0], evicted[4], live_count[9:5]
//  cfg_*   | in  | cfg_we             | cfg_wdata: lifetime[15:0]
//
// One word at a time. An allocate that finds a free slot ends its scan there; an
// allocate into a full pool and a tick sweep every slot. The scan length is set by
// the sweep of the expiry RAM, one entry per cycle through its single read port.
// Reset clears the busy bits and the live count at once; expiry RAM needs no clearing.
// A result waiting at m_* does not block accepting the next word; the sequencer
// holds in its final cycle only until the output register is free.
module ttl_slot_allocator #(
	parameter int SLOTS = tsa_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tsa_pkg::EXP_W-1:0]        s_tdata,   // [31:0] now_time
	input  logic [0:0]                       s_tuser,   // [0] mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tsa_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [3:0] slot, [4] evicted, [9:5] live_count
	input  logic                             cfg_we,
	input  logic [tsa_pkg::LIFE_W-1:0]       cfg_wdata  // [15:0] lifetime
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [tsa_pkg::LIFE_W-1:0] lifetime_q;
	logic                       idle;
	logic                       start;
	logic                       res_ready;
	tsa_pkg::res_t              res;
	logic                       ram_we;
	logic [IW-1:0]              ram_waddr;
	logic [tsa_pkg::EXP_W-1:0]  ram_wdata;
	logic                       ram_re;
	logic [IW-1:0]              ram_raddr;
	logic [tsa_pkg::EXP_W-1:0]  ram_rdata;
	logic                       m_valid_q;
	logic [tsa_pkg::OUT_TDATA_W-1:0] m_data_q;

	// Accept a word only while the sequencer is idle.
	assign s_tready  = idle;
	assign start     = s_tvalid && s_tready;
	// Output register is free when empty or being drained this cycle.
	assign res_ready = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Lifetime register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= tsa_pkg::LIFE_W'(tsa_pkg::LIFE_RESET);
		end else if (cfg_we) begin
			lifetime_q <= cfg_wdata;
		end
	end

	tsa_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (s_tuser[0]),
		.now_time  (s_tdata),
		.lifetime  (lifetime_q),
		.idle      (idle),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_ready (res_ready),
		.res       (res)
	);

	// Expiry time per slot; read data is used only while the slot is busy.
	tsa_ram #(
		.WIDTH (tsa_pkg::EXP_W),
		.DEPTH (SLOTS)
	) u_exp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: load a finished result, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			m_data_q <= tsa_pkg::OUT_TDATA_W'({res.live_count, res.evicted, res.slot});
		end
	end

endmodule

// ----- rtl/tsa_chk.sv -----
// Port-level checker for the slot allocator, bound to the top level.
module tsa_chk #(
	parameter int SLOTS = tsa_pkg::SLOTS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tsa_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam bit NARROW = (SLOTS < 32);
	localparam logic [tsa_pkg::LIVE_W-1:0] FULL = tsa_pkg::LIVE_W'(SLOTS);

	// Live count never exceeds the pool size (checked only for pools under 32 slots).
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(NARROW && m_tvalid) |-> (m_tdata[9:5] <= FULL))
		else $error("live count above pool size");

	// An eviction happens only when the pool is full.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(NARROW && m_tvalid && m_tdata[4]) |-> (m_tdata[9:5] == FULL))
		else $error("eviction with free slot");

	// One word in flight: ready drops right after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted during scan");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind ttl_slot_allocator tsa_chk #(
	.SLOTS (SLOTS)
) u_tsa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
